[rtl/raw_to_pcm16_saturate_with_stats_defines.svh]
// ---------------------------------------------------------------------------
// raw_to_pcm16_saturate_with_stats_defines.svh
// Assertion macros used by the checker file of the PCM converter.
// ---------------------------------------------------------------------------
`ifndef RAW_TO_PCM16_SATURATE_WITH_STATS_DEFINES_SVH
`define RAW_TO_PCM16_SATURATE_WITH_STATS_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define R2P_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("r2p: same-cycle property violated");

// next-cycle implication, held off while reset is low
`define R2P_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("r2p: next-cycle property violated");

`endif

[rtl/r2p_pkg.sv]
// ---------------------------------------------------------------------------
// r2p_pkg
// Types and constants of the raw-to-PCM16 converter with block statistics.
// ---------------------------------------------------------------------------
package r2p_pkg;

    localparam int MAX_BLOCK_DEF = 1024;     // default block length limit
    localparam int Q_DEPTH       = 4;        // front-to-back queue depth
    localparam int SHIFT_W       = 5;
    localparam int OUT_CNT_W     = 11;       // width of count fields on the port
    localparam int SQ_W          = 31;       // square of a 16-bit sample
    localparam int ROOT_STEPS    = 16;       // radix-4 root digits of a 32-bit word

    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd14;
    localparam logic signed [15:0] PCM_MAX   = 16'sh7fff;
    localparam logic signed [15:0] PCM_MIN   = 16'sh8000;

    typedef struct packed {
        logic signed [31:0] raw_sample;
        logic               last_in_block;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]    pcm_sample;
        logic                  sample_clipped;
        logic                  block_end;
        logic [OUT_CNT_W-1:0]  block_count;
        logic signed [15:0]    block_min;
        logic signed [15:0]    block_max;
        logic [15:0]           block_rms;
        logic [OUT_CNT_W-1:0]  block_clip_count;
        logic                  block_overrun;
    } t_out_item;

    // fixed-width part of one queue entry
    typedef struct packed {
        logic signed [15:0] pcm;
        logic               clipped;
        logic               last;
        logic signed [15:0] blk_min;
        logic signed [15:0] blk_max;
        logic               overrun;
    } t_smp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[rtl/raw_to_pcm16_saturate_with_stats.sv]
// ---------------------------------------------------------------------------
// raw_to_pcm16_saturate_with_stats
// Requantizes signed 32-bit microphone words to 16-bit PCM with saturation
// and reports min, max, clip count and rms of each block on its last item.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------
//  input     in         i_in_valid / o_in_ready   i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_ready o_out_item (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (shift amount)
//
//  Ordinary items flow at one per cycle while the queue and output drain;
//  an accepted item passes stage A, stage B, the queue and the output
//  register. A block-closing item holds the back end for a bit-serial
//  divide, then a radix-4 root. The 4-entry queue lets the front keep
//  taking items meanwhile.
//  Reset is synchronous, active low; shift amount returns to 14.
//  The config port is always ready; writes are legal only while idle.

module raw_to_pcm16_saturate_with_stats
    import r2p_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SHIFT_W-1:0] i_cfg_data
);

    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W  = SQ_W - 1 + CNT_W;          // worst-case sum of squares
    localparam int DATA_W = $bits(t_smp) + 2 * CNT_W + SUM_W;

    logic [SHIFT_W-1:0] r_shift;
    logic               push;
    logic [DATA_W-1:0]  push_data;
    logic               pop;
    logic [DATA_W-1:0]  head;
    t_qstat             q_stat;

    // shift register: writes always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RST;
        end else if (i_cfg_valid) begin
            r_shift <= i_cfg_data;
        end
    end

    // front: convert, square, accumulate; one queue entry per item
    r2p_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (r_shift),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decoupling queue
    r2p_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    // back: rms on block ends, output register
    r2p_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/r2p_front.sv]
// ---------------------------------------------------------------------------
// r2p_front
// Accepts raw words, shifts and saturates them, squares, and folds each
// sample into the block statistics; pushes one entry per item to the queue.
// ---------------------------------------------------------------------------
module r2p_front
    import r2p_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF,
    localparam int CNT_W    = $clog2(MAX_BLOCK + 1),
    localparam int SUM_W    = SQ_W - 1 + CNT_W,
    localparam int DATA_W   = $bits(t_smp) + 2 * CNT_W + SUM_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SHIFT_W-1:0] i_shift,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    input  t_qstat             i_q_stat,
    output logic               o_push,
    output logic [DATA_W-1:0]  o_push_data
);

    logic adv;

    // stage A: converted sample
    logic               r_a_vld;
    logic signed [15:0] r_a_pcm;
    logic               r_a_clip;
    logic               r_a_last;
    // stage B: sample and its square
    logic               r_b_vld;
    logic signed [15:0] r_b_pcm;
    logic               r_b_clip;
    logic               r_b_last;
    logic [SQ_W-1:0]    r_b_sq;
    // block accumulators
    logic signed [15:0] r_min;
    logic signed [15:0] r_max;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_clip_cnt;
    logic [CNT_W-1:0]   r_tally;
    logic               r_ovr;

    logic signed [31:0] shifted;
    logic               in_range;
    logic signed [15:0] cvt_pcm;
    logic signed [31:0] prod;
    logic               acc;
    logic signed [15:0] n_min;
    logic signed [15:0] n_max;
    logic [SUM_W-1:0]   n_sum;
    logic [CNT_W-1:0]   n_clip_cnt;
    logic [CNT_W-1:0]   n_tally;
    logic               n_ovr;
    t_smp               ent;

    // whole front stalls only when the last stage cannot drain
    assign adv        = !(r_b_vld && i_q_stat.full);
    assign o_in_ready = adv;

    assign shifted  = i_in_item.raw_sample >>> i_shift;
    assign in_range = (&shifted[31:15]) | ~(|shifted[31:15]);
    assign cvt_pcm  = in_range ? shifted[15:0] : (shifted[31] ? PCM_MIN : PCM_MAX);

    assign prod = r_a_pcm * r_a_pcm;

    always_comb begin
        acc        = r_tally < CNT_W'(MAX_BLOCK);
        n_min      = (acc && r_b_pcm < r_min) ? r_b_pcm : r_min;
        n_max      = (acc && r_b_pcm > r_max) ? r_b_pcm : r_max;
        n_sum      = acc ? r_sum + SUM_W'(r_b_sq) : r_sum;
        n_clip_cnt = (acc && r_b_clip) ? r_clip_cnt + 1'b1 : r_clip_cnt;
        n_tally    = acc ? r_tally + 1'b1 : r_tally;
        n_ovr      = r_ovr | !acc;
        ent.pcm     = r_b_pcm;
        ent.clipped = r_b_clip;
        ent.last    = r_b_last;
        ent.blk_min = n_min;
        ent.blk_max = n_max;
        ent.overrun = n_ovr;
    end

    assign o_push      = adv && r_b_vld;
    assign o_push_data = {ent, n_clip_cnt, n_tally, n_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_min      <= PCM_MAX;
            r_max      <= PCM_MIN;
            r_sum      <= '0;
            r_clip_cnt <= '0;
            r_tally    <= '0;
            r_ovr      <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            if (r_b_vld) begin
                if (r_b_last) begin
                    r_min      <= PCM_MAX;
                    r_max      <= PCM_MIN;
                    r_sum      <= '0;
                    r_clip_cnt <= '0;
                    r_tally    <= '0;
                    r_ovr      <= 1'b0;
                end else begin
                    r_min      <= n_min;
                    r_max      <= n_max;
                    r_sum      <= n_sum;
                    r_clip_cnt <= n_clip_cnt;
                    r_tally    <= n_tally;
                    r_ovr      <= n_ovr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_pcm  <= cvt_pcm;
            r_a_clip <= !in_range;
            r_a_last <= i_in_item.last_in_block;
            r_b_pcm  <= r_a_pcm;
            r_b_clip <= r_a_clip;
            r_b_last <= r_a_last;
            r_b_sq   <= prod[SQ_W-1:0];
        end
    end

endmodule

[rtl/r2p_queue.sv]
// ---------------------------------------------------------------------------
// r2p_queue
// Small FIFO between front and back; head entry is shown without a pop.
// ---------------------------------------------------------------------------
module r2p_queue
    import r2p_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_head,
    output t_qstat            o_stat
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W:0]    r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == (PTR_W + 1)'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

[rtl/r2p_back.sv]
// ---------------------------------------------------------------------------
// r2p_back
// Drains the queue into the output register. Block-closing entries first run
// a bit-serial divide (sum / count) and a radix-4 integer square root.
// ---------------------------------------------------------------------------
module r2p_back
    import r2p_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF,
    localparam int CNT_W    = $clog2(MAX_BLOCK + 1),
    localparam int SUM_W    = SQ_W - 1 + CNT_W,
    localparam int DATA_W   = $bits(t_smp) + 2 * CNT_W + SUM_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qstat            i_q_stat,
    input  logic [DATA_W-1:0] i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam int SMP_W  = $bits(t_smp);
    localparam int SR_W   = 18;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        r_st;
    logic [1:0]        n_st;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [SUM_W-1:0]  r_dq;
    logic [SUM_W-1:0]  n_dq;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  n_rem;
    logic [31:0]       r_x;
    logic [31:0]       n_x;
    logic [15:0]       r_root;
    logic [15:0]       n_root;
    logic [SR_W-1:0]   r_srem;
    logic [SR_W-1:0]   n_srem;
    logic              r_out_vld;
    t_out_item         r_out;
    t_out_item         n_out;
    logic              load;

    t_smp                   h_smp;
    logic [CNT_W-1:0]       h_clip;
    logic [CNT_W-1:0]       h_cnt;
    logic [SUM_W-1:0]       h_sum;
    logic [CNT_W+10:0]      cnt_ext;
    logic [CNT_W+10:0]      clip_ext;
    logic                   out_free;
    logic [CNT_W:0]         rem_sh;
    logic [CNT_W:0]         rem_diff;
    logic                   div_ge;
    logic [SR_W+1:0]        srem_sh;
    logic [SR_W+1:0]        trial;
    logic                   sq_ge;

    assign h_smp    = t_smp'(i_head[DATA_W-1 -: SMP_W]);
    assign h_clip   = i_head[2*CNT_W+SUM_W-1 -: CNT_W];
    assign h_cnt    = i_head[CNT_W+SUM_W-1 -: CNT_W];
    assign h_sum    = i_head[SUM_W-1:0];
    assign cnt_ext  = {11'b0, h_cnt};
    assign clip_ext = {11'b0, h_clip};
    assign out_free = !r_out_vld || i_out_ready;

    // one quotient bit per cycle
    assign rem_sh   = {r_rem, r_dq[SUM_W-1]};
    assign div_ge   = rem_sh >= {1'b0, h_cnt};
    assign rem_diff = rem_sh - {1'b0, h_cnt};

    // one root bit per cycle
    assign srem_sh = {r_srem, r_x[31:30]};
    assign trial   = (SR_W + 2)'({r_root, 2'b01});
    assign sq_ge   = srem_sh >= trial;

    always_comb begin
        n_st   = r_st;
        n_step = r_step;
        n_dq   = r_dq;
        n_rem  = r_rem;
        n_x    = r_x;
        n_root = r_root;
        n_srem = r_srem;
        load   = 1'b0;
        o_pop  = 1'b0;

        n_out                  = '0;
        n_out.pcm_sample       = h_smp.pcm;
        n_out.sample_clipped   = h_smp.clipped;

        case (r_st)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (h_smp.last) begin
                        n_dq   = h_sum;
                        n_rem  = '0;
                        n_step = STEP_W'(SUM_W - 1);
                        n_st   = ST_DIV;
                    end else if (out_free) begin
                        load  = 1'b1;
                        o_pop = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                n_rem = div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                n_dq  = {r_dq[SUM_W-2:0], div_ge};
                if (r_step == '0) begin
                    // quotient never exceeds 2^30
                    n_x    = {1'b0, n_dq[SQ_W-1:0]};
                    n_root = '0;
                    n_srem = '0;
                    n_step = STEP_W'(ROOT_STEPS - 1);
                    n_st   = ST_SQRT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_SQRT: begin
                n_srem = sq_ge ? SR_W'(srem_sh - trial) : srem_sh[SR_W-1:0];
                n_root = {r_root[14:0], sq_ge};
                n_x    = {r_x[29:0], 2'b00};
                if (r_step == '0) begin
                    n_st = ST_DONE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load  = 1'b1;
                    o_pop = 1'b1;
                    n_st  = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase

        if (r_st == ST_DONE) begin
            n_out.block_end        = 1'b1;
            n_out.block_count      = cnt_ext[OUT_CNT_W-1:0];
            n_out.block_min        = h_smp.blk_min;
            n_out.block_max        = h_smp.blk_max;
            n_out.block_rms        = r_root;
            n_out.block_clip_count = clip_ext[OUT_CNT_W-1:0];
            n_out.block_overrun    = h_smp.overrun;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_x    <= n_x;
        r_root <= n_root;
        r_srem <= n_srem;
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

[rtl/r2p_checker.sv]
// ---------------------------------------------------------------------------
// r2p_checker
// Port-level checks on the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "raw_to_pcm16_saturate_with_stats_defines.svh"

module r2p_checker
    import r2p_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input t_in_item           i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_out_item          o_out_item
);

    logic stalled;
    logic stats_zero;
    logic at_rail;
    logic in_wait;
    logic blk_out;
    logic min_le_max;

    assign stalled    = o_out_valid && !i_out_ready;
    assign stats_zero = o_out_item.block_count == '0 && o_out_item.block_rms == '0
                        && o_out_item.block_clip_count == '0
                        && o_out_item.block_min == '0 && o_out_item.block_max == '0
                        && !o_out_item.block_overrun;
    assign at_rail    = o_out_item.pcm_sample == PCM_MAX
                        || o_out_item.pcm_sample == PCM_MIN;
    assign in_wait    = i_in_valid && !o_in_ready;
    assign blk_out    = o_out_valid && o_out_item.block_end;
    assign min_le_max = $signed(o_out_item.block_min) <= $signed(o_out_item.block_max);

    `R2P_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, stalled, o_out_valid && $stable(o_out_item))
    `R2P_ASSERT_IMP(a_plain_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.block_end, stats_zero)
    `R2P_ASSERT_IMP(a_clip_rail, i_clk, i_rst_n, o_out_valid && o_out_item.sample_clipped, at_rail)
    `R2P_ASSERT_IMP(a_min_max, i_clk, i_rst_n, blk_out, min_le_max)
    `R2P_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid && $stable(i_in_item))

endmodule

bind raw_to_pcm16_saturate_with_stats r2p_checker u_r2p_checker (.*);

[test/raw_to_pcm16_saturate_with_stats_tb.sv]
// ---------------------------------------------------------------------------
// raw_to_pcm16_saturate_with_stats_tb
// Self-checking bench for the PCM requantizer. Each raw word is shifted and
// saturated to 16 bits, and block min/max/clip/rms is checked on the last
// item of every block against an in-bench model. A directed table comes
// first, then random blocks over several shift settings.
// ---------------------------------------------------------------------------
module raw_to_pcm16_saturate_with_stats_tb;
    import r2p_pkg::*;

    localparam int BLK_LIMIT      = MAX_BLOCK_DEF;
    // A closing item holds the back end through divide and root; add stall
    // and gap slack, then a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 130;        // margin over the worst back-end hold
    localparam int N_DIR          = 19;
    localparam int N_PHASES       = 10;
    localparam int PHASE_ITEMS    = 88;

    typedef enum bit {ROW_CFG, ROW_ITEM} t_row_kind;

    // one line of the directed table; for ROW_CFG, raw holds the shift
    typedef struct {
        t_row_kind   kind;
        logic [31:0] raw;
        logic        last;
        bit          typed;      // want was written by hand
        t_out_item   want;
    } t_row;

    // hand-written expectation, lined up with the input item it belongs to
    typedef struct {
        bit        typed;
        t_out_item want;
    } t_pinned;

    // -----------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // -----------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_item;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [SHIFT_W-1:0] i_cfg_data  = '0;

    always #1 i_clk = ~i_clk;

    raw_to_pcm16_saturate_with_stats #(
        .MAX_BLOCK (BLK_LIMIT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // -----------------------------------------------------------------------
    // Model state: shift register plus the open block's accumulators.
    // Values below are the reset values.
    // -----------------------------------------------------------------------
    logic [SHIFT_W-1:0] cur_shift   = SHIFT_RST;
    logic signed [15:0] blk_min     = PCM_MAX;
    logic signed [15:0] blk_max     = PCM_MIN;
    longint unsigned    blk_sq_sum  = 0;
    int                 blk_clips   = 0;
    int                 blk_len     = 0;
    bit                 blk_overrun = 1'b0;

    t_out_item pending_pcm [$];     // results still owed by the DUT
    t_pinned   pinned_q [$];        // per-item hand expectations
    t_row      dir_rows [N_DIR];

    int n_fail          = 0;
    int n_samples       = 0;
    int n_results       = 0;
    int n_blocks        = 0;
    int n_clipped       = 0;
    int n_overrun_blks  = 0;
    int n_shift_writes  = 0;
    int stuck_cycles    = 0;

    // sender / receiver idling knobs; gap switch and stall rate set per phase
    bit tx_gaps_on     = 1'b0;
    int tx_burst_left  = 0;
    int rx_stall_pct   = 0;
    int rx_stall_left  = 0;

    // floor square root, one result bit at a time from the top
    function automatic logic [15:0] floor_root(longint unsigned x);
        longint unsigned root, trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root[15:0];
    endfunction

    // Converts one raw word and folds it into the open block. On the last
    // item it also fills in the block report and starts a fresh block.
    function automatic t_out_item requantize_and_tally(t_in_item it);
        t_out_item          res;
        logic signed [31:0] shifted;
        logic signed [15:0] pcm;
        bit                 clip;
        longint unsigned    mean_sq;
        res     = '0;
        clip    = 1'b0;
        shifted = it.raw_sample >>> cur_shift;
        if (shifted > 32'sd32767) begin
            pcm  = PCM_MAX;
            clip = 1'b1;
        end else if (shifted < -32'sd32768) begin
            pcm  = PCM_MIN;
            clip = 1'b1;
        end else begin
            pcm = shifted[15:0];
        end

        // past the block limit the sample is converted but not counted
        if (blk_len < BLK_LIMIT) begin
            if (pcm < blk_min)
                blk_min = pcm;
            if (pcm > blk_max)
                blk_max = pcm;
            blk_sq_sum += longint'(pcm) * longint'(pcm);
            if (clip)
                blk_clips++;
            blk_len++;
        end else begin
            blk_overrun = 1'b1;
        end

        res.pcm_sample     = pcm;
        res.sample_clipped = clip;
        if (it.last_in_block) begin
            // blk_len is at least 1 here: the last item always fits or the
            // block is already full
            mean_sq              = blk_sq_sum / longint'(blk_len);
            res.block_end        = 1'b1;
            res.block_count      = blk_len[OUT_CNT_W-1:0];
            res.block_min        = blk_min;
            res.block_max        = blk_max;
            res.block_rms        = floor_root(mean_sq);
            res.block_clip_count = blk_clips[OUT_CNT_W-1:0];
            res.block_overrun    = blk_overrun;
            blk_min     = PCM_MAX;
            blk_max     = PCM_MIN;
            blk_sq_sum  = 0;
            blk_clips   = 0;
            blk_len     = 0;
            blk_overrun = 1'b0;
        end
        return res;
    endfunction

    function automatic t_out_item mk_out(int pcm, bit clip, bit fin = 1'b0,
                                         int cnt = 0, int mn = 0, int mx = 0,
                                         int rms = 0, int clips = 0,
                                         bit ovr = 1'b0);
        t_out_item r;
        r.pcm_sample       = pcm[15:0];
        r.sample_clipped   = clip;
        r.block_end        = fin;
        r.block_count      = cnt[OUT_CNT_W-1:0];
        r.block_min        = mn[15:0];
        r.block_max        = mx[15:0];
        r.block_rms        = rms[15:0];
        r.block_clip_count = clips[OUT_CNT_W-1:0];
        r.block_overrun    = ovr;
        return r;
    endfunction

    task automatic check_field(string nm, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, want, got);
            n_fail++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Scoreboard. Sampled at the rising edge, so it sees the pre-edge values
    // of both the DUT and the bench drivers.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_out_item want_res;
        t_out_item model_res;
        t_pinned   pin;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                cur_shift = i_cfg_data;

            if (o_out_valid && i_out_ready) begin
                if (pending_pcm.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h",
                             $time, o_out_item);
                    n_fail++;
                end else begin
                    want_res = pending_pcm.pop_front();
                    n_results++;
                    check_field("pcm_sample", want_res.pcm_sample,
                                o_out_item.pcm_sample);
                    check_field("sample_clipped", want_res.sample_clipped,
                                o_out_item.sample_clipped);
                    check_field("block_end", want_res.block_end,
                                o_out_item.block_end);
                    check_field("block_count", want_res.block_count,
                                o_out_item.block_count);
                    check_field("block_min", want_res.block_min,
                                o_out_item.block_min);
                    check_field("block_max", want_res.block_max,
                                o_out_item.block_max);
                    check_field("block_rms", want_res.block_rms,
                                o_out_item.block_rms);
                    check_field("block_clip_count", want_res.block_clip_count,
                                o_out_item.block_clip_count);
                    check_field("block_overrun", want_res.block_overrun,
                                o_out_item.block_overrun);
                end
            end

            if (i_in_valid && o_in_ready) begin
                pin       = pinned_q.pop_front();
                model_res = requantize_and_tally(i_in_item);
                n_samples++;
                if (model_res.sample_clipped)
                    n_clipped++;
                if (model_res.block_end)
                    n_blocks++;
                if (model_res.block_overrun)
                    n_overrun_blks++;
                // the model state always advances; a hand-written row
                // replaces what is checked
                pending_pcm.push_back(pin.typed ? pin.want : model_res);
            end
        end
    end

    // receiver: ready except during stalls, which start at random at
    // the rate set per phase
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
            rx_stall_left = $urandom_range(7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog: long stretch with no item moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Driver tasks
    // -----------------------------------------------------------------------

    // Drops the input valid and waits until every owed result has arrived.
    // The check runs on the falling edge, clear of the scoreboard's updates.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_pcm.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_shift(logic [SHIFT_W-1:0] sh);
        wait_drained();
        i_cfg_data  <= sh;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_shift_writes++;
    endtask

    // Presents one item and returns at the edge that takes it. Valid is left
    // high so that a following item goes out back to back.
    task automatic send_sample(logic [31:0] raw, logic last, bit typed,
                               t_out_item want);
        t_pinned pin;
        pin.typed = typed;
        pin.want  = want;
        pinned_q.push_back(pin);
        i_in_item  <= '{raw_sample: raw, last_in_block: last};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // raw word mix: full random, near the clip points of the current shift,
    // small values, and the corner words
    function automatic logic [31:0] pick_raw(logic [SHIFT_W-1:0] sh);
        longint      near_val;
        logic [31:0] lsb, v;
        int          d, mag_bits;
        lsb = (sh == 0) ? 32'd0 : ($urandom() & ((32'd1 << sh) - 1));
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                return $urandom();
            end
            3, 4, 8: begin
                d = int'($urandom_range(4)) - 2;
                if ($urandom_range(1))
                    near_val = longint'(32767 + d) << sh;
                else
                    near_val = longint'(-32768 + d) << sh;
                v = near_val[31:0] | lsb;
                return v;
            end
            5, 6, 9: begin
                mag_bits = sh + 12;
                if (mag_bits > 31)
                    mag_bits = 31;
                v = $urandom() & ((32'd1 << mag_bits) - 1);
                if ($urandom_range(1))
                    v = -v;
                return v;
            end
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    // One block of len items with the last mark on the final one. When gaps
    // are on, the sender runs in bursts of up to 17 items with idle gaps
    // between them. pause_at holds the sender until everything is drained.
    task automatic send_block(int len, logic [SHIFT_W-1:0] sh, int pause_at = -1);
        for (int i = 0; i < len; i++) begin
            if (i == pause_at)
                wait_drained();
            send_sample(pick_raw(sh), (i == len - 1), 1'b0, mk_out(0, 1'b0));
            if (tx_gaps_on) begin
                if (tx_burst_left == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    tx_burst_left = $urandom_range(1, 16);
                end else begin
                    tx_burst_left--;
                end
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        logic [SHIFT_W-1:0] sh;
        int                 phase_sent;
        int                 len;

        // Directed table. Shift starts at its reset value of 14. Rows with a
        // hand expectation cover both clip points, exact full scale without a
        // clip, single-item blocks, the rms of a full-scale negative block
        // and the shift extremes 0 and 31.
        dir_rows = '{
            '{ROW_ITEM, 32'h0000_4000, 1'b0, 1'b1, mk_out(1, 1'b0)},
            '{ROW_ITEM, 32'h7fff_ffff, 1'b0, 1'b1, mk_out(32767, 1'b1)},
            '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, mk_out(-32768, 1'b1)},
            '{ROW_ITEM, 32'hffff_ffff, 1'b0, 1'b1, mk_out(-1, 1'b0)},
            '{ROW_ITEM, 32'h1fff_c000, 1'b0, 1'b1, mk_out(32767, 1'b0)},
            '{ROW_ITEM, 32'he000_0000, 1'b0, 1'b1, mk_out(-32768, 1'b0)},
            '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b0, mk_out(0, 1'b0)},
            '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b1,
              mk_out(0, 1'b0, 1'b1, 1, 0, 0, 0, 0, 1'b0)},
            '{ROW_CFG,  32'd0,         1'b0, 1'b0, mk_out(0, 1'b0)},
            '{ROW_ITEM, 32'h0000_7fff, 1'b0, 1'b1, mk_out(32767, 1'b0)},
            '{ROW_ITEM, 32'h0000_8000, 1'b0, 1'b1, mk_out(32767, 1'b1)},
            '{ROW_ITEM, 32'hffff_8000, 1'b0, 1'b1, mk_out(-32768, 1'b0)},
            '{ROW_ITEM, 32'hffff_7fff, 1'b0, 1'b1, mk_out(-32768, 1'b1)},
            '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b0, mk_out(0, 1'b0)},
            '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1,
              mk_out(-32768, 1'b1, 1'b1, 1, -32768, -32768, 32768, 1, 1'b0)},
            '{ROW_CFG,  32'd31,        1'b0, 1'b0, mk_out(0, 1'b0)},
            '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, mk_out(-1, 1'b0)},
            '{ROW_ITEM, 32'h7fff_ffff, 1'b0, 1'b1, mk_out(0, 1'b0)},
            '{ROW_ITEM, 32'hffff_ffff, 1'b1, 1'b1,
              mk_out(-1, 1'b0, 1'b1, 3, -1, 0, 0, 0, 1'b0)}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_shift(dir_rows[r].raw[SHIFT_W-1:0]);
            else
                send_sample(dir_rows[r].raw, dir_rows[r].last, dir_rows[r].typed,
                            dir_rows[r].want);
        end

        // Random phases. Phase 0 runs with no idling on either side; the
        // rest have receiver stalls, and odd phases add sender bursts. Phase 2
        // holds the sender mid-block until the pipe is empty.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: sh = 5'd0;
                1: sh = 5'd31;
                2: sh = 5'd14;
                3: sh = 5'd16;
                4: sh = 5'd8;
                5: sh = 5'd20;
                6: sh = 5'd1;
                7: sh = 5'd30;
                default: sh = SHIFT_W'($urandom_range(31));
            endcase
            write_shift(sh);
            tx_gaps_on    = (ph % 2 == 1);
            tx_burst_left = 0;
            case (ph % 3)
                0: rx_stall_pct = (ph == 0) ? 0 : 10;
                1: rx_stall_pct = 30;
                default: rx_stall_pct = 60;
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
                if (len > PHASE_ITEMS - phase_sent)
                    len = PHASE_ITEMS - phase_sent;
                if (ph == 2 && phase_sent == 0)
                    send_block(len, sh, len / 2);
                else
                    send_block(len, sh);
                phase_sent += len;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples in %0d blocks over %0d shift writes;",
                 n_samples, n_blocks, n_shift_writes);
        $display("%0d samples saturated, %0d blocks overran, %0d results checked, %0d errors.",
                 n_clipped, n_overrun_blks, n_results, n_fail);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
